@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; each macro samples on clk and reports through $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define RCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RCP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rcp_pkg.sv @@
// shared types, constants and helpers for the radial projection residual core
// no dependencies
package rcp_pkg;

  localparam int LAT       = 51;  // accept edge to result strobe
  localparam int DIV_STEPS = 30;  // fraction bits of the normalized coordinates
  localparam int OBS_DLY   = 48;  // observed pixel delay up to the pixel stage
  localparam int ZERO_DLY  = 45;  // zero-depth flag delay up to the pixel stage

  typedef enum logic [2:0] {
    REG_DIST_CENTER_X = 3'd0,
    REG_DIST_CENTER_Y = 3'd1,
    REG_RADIAL_K2     = 3'd2,
    REG_RADIAL_K4     = 3'd3,
    REG_RADIAL_K6     = 3'd4,
    REG_PRINCIPAL_X   = 3'd5,
    REG_PRINCIPAL_Y   = 3'd6,
    REG_FOCAL_LENGTH  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] dist_center_x;
    logic signed [31:0] dist_center_y;
    logic signed [31:0] radial_k2;
    logic signed [31:0] radial_k4;
    logic signed [31:0] radial_k6;
    logic signed [31:0] principal_x;
    logic signed [31:0] principal_y;
    logic        [30:0] focal_length;
  } cfg_t;

  localparam logic signed [31:0] PRINCIPAL_X_RST  = 32'sd196608000;
  localparam logic signed [31:0] PRINCIPAL_Y_RST  = 32'sd131072000;
  localparam logic        [30:0] FOCAL_LENGTH_RST = 31'd393216000;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'(S32_MAX)) begin
      res = S32_MAX;
    end else if (v < 64'(S32_MIN)) begin
      res = S32_MIN;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/rcp_mul.sv @@
// two-stage signed multiplier, 36 x 48 bits, b split in two partial products
// uses nothing else
module rcp_mul (
  input  logic               clk,
  input  logic signed [35:0] a,
  input  logic signed [47:0] b,
  output logic signed [83:0] p
);
  logic signed [60:0] pl;
  logic signed [59:0] ph;
  logic signed [60:0] pl_r;
  logic signed [59:0] ph_r;

  always_comb begin
    pl = 61'(a) * 61'($signed({1'b0, b[23:0]}));
    ph = 60'(a) * 60'($signed(b[47:24]));
  end

  always_ff @(posedge clk) begin
    pl_r <= pl;
    ph_r <= ph;
    p    <= (84'(ph_r) <<< 24) + 84'(pl_r);
  end
endmodule

@@ rtl/core/rcp_rotate.sv @@
// camera frame point: ground minus centre, then first-order small rotation
// three register stages; uses rcp_pkg
module rcp_rotate (
  input  logic               clk,
  input  logic signed [31:0] ground_x,
  input  logic signed [31:0] ground_y,
  input  logic signed [31:0] ground_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] omega_x,
  input  logic signed [31:0] omega_y,
  input  logic signed [31:0] omega_z,
  output logic signed [35:0] xc,
  output logic signed [35:0] yc,
  output logic signed [35:0] zc,
  output logic               zero
);
  import rcp_pkg::*;

  logic signed [32:0] dx_r, dy_r, dz_r, dx2_r, dy2_r, dz2_r;
  logic signed [31:0] wx_r, wy_r, wz_r;
  logic signed [64:0] prod [0:5];
  logic signed [34:0] p_r  [0:5];
  logic signed [35:0] xc_nxt, yc_nxt, zc_nxt;

  always_comb begin
    prod[0] = 65'(wy_r) * 65'(dz_r);
    prod[1] = 65'(wz_r) * 65'(dy_r);
    prod[2] = 65'(wz_r) * 65'(dx_r);
    prod[3] = 65'(wx_r) * 65'(dz_r);
    prod[4] = 65'(wx_r) * 65'(dy_r);
    prod[5] = 65'(wy_r) * 65'(dx_r);
    xc_nxt  = 36'(dx2_r) + 36'(p_r[0]) - 36'(p_r[1]);
    yc_nxt  = 36'(dy2_r) + 36'(p_r[2]) - 36'(p_r[3]);
    zc_nxt  = 36'(dz2_r) + 36'(p_r[4]) - 36'(p_r[5]);
  end

  always_ff @(posedge clk) begin
    dx_r  <= 33'(ground_x) - 33'(center_x);
    dy_r  <= 33'(ground_y) - 33'(center_y);
    dz_r  <= 33'(ground_z) - 33'(center_z);
    wx_r  <= omega_x;
    wy_r  <= omega_y;
    wz_r  <= omega_z;
    dx2_r <= dx_r;
    dy2_r <= dy_r;
    dz2_r <= dz_r;
    for (int i = 0; i < 6; i++) begin
      p_r[i] <= 35'(prod[i] >>> 30);
    end
    xc   <= xc_nxt;
    yc   <= yc_nxt;
    zc   <= zc_nxt;
    zero <= (zc_nxt == '0);
  end
endmodule

@@ rtl/core/rcp_div.sv @@
// pipelined restoring divider, Q2.30 quotient truncated toward zero, saturated
// one quotient bit per stage, then a sign and saturation stage; uses rcp_pkg
module rcp_div (
  input  logic               clk,
  input  logic signed [35:0] num,
  input  logic signed [35:0] den,
  output logic signed [31:0] q
);
  import rcp_pkg::*;

  logic [35:0] un, ud;
  logic        ip0;
  logic [36:0] r_r   [0:DIV_STEPS];
  logic [29:0] f_r   [0:DIV_STEPS];
  logic [35:0] ud_r  [0:DIV_STEPS];
  logic        ip_r  [0:DIV_STEPS];
  logic        neg_r [0:DIV_STEPS];
  logic        sat_r [0:DIV_STEPS];
  logic [31:0] m;

  always_comb begin
    un  = num[35] ? 36'(-num) : 36'(num);
    ud  = den[35] ? 36'(-den) : 36'(den);
    ip0 = (un >= ud);
    m   = {1'b0, ip_r[DIV_STEPS], f_r[DIV_STEPS]};
  end

  always_ff @(posedge clk) begin
    r_r[0]   <= {1'b0, ip0 ? (un - ud) : un};
    f_r[0]   <= '0;
    ud_r[0]  <= ud;
    ip_r[0]  <= ip0;
    neg_r[0] <= num[35] ^ den[35];
    sat_r[0] <= ({1'b0, un} >= {ud, 1'b0});
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [36:0] sh;
    logic        ge;
    always_comb begin
      sh = {r_r[k][35:0], 1'b0};
      ge = (sh >= {1'b0, ud_r[k]});
    end
    always_ff @(posedge clk) begin
      r_r[k+1]   <= ge ? (sh - {1'b0, ud_r[k]}) : sh;
      f_r[k+1]   <= {f_r[k][28:0], ge};
      ud_r[k+1]  <= ud_r[k];
      ip_r[k+1]  <= ip_r[k];
      neg_r[k+1] <= neg_r[k];
      sat_r[k+1] <= sat_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (sat_r[DIV_STEPS]) begin
      q <= neg_r[DIV_STEPS] ? S32_MIN : S32_MAX;
    end else begin
      q <= neg_r[DIV_STEPS] ? -$signed(m) : $signed(m);
    end
  end
endmodule

@@ rtl/core/rcp_distort.sv @@
// radial distortion about the distortion centre, k2 k4 k6 terms
// 13 register stages; uses rcp_pkg and rcp_mul
module rcp_distort (
  input  logic                clk,
  input  rcp_pkg::cfg_t       cfg,
  input  logic signed [31:0]  xn,
  input  logic signed [31:0]  yn,
  output logic signed [47:0]  xd,
  output logic signed [47:0]  yd
);
  import rcp_pkg::*;

  logic signed [31:0] ex_d_r [0:9];
  logic signed [31:0] ey_d_r [0:9];
  logic signed [31:0] xn_d_r [0:11];
  logic signed [31:0] yn_d_r [0:11];
  logic signed [63:0] sx_r, sy_r;
  logic signed [47:0] r2_r;
  logic signed [47:0] r2_d_r [0:1];
  logic signed [47:0] kr2_d_r [0:3];
  logic signed [47:0] kr4_d_r [0:1];
  logic signed [47:0] dist_r;
  logic signed [83:0] pa, pb, pc, pd, pe, pf, pg;
  logic signed [47:0] r4, r6;

  always_comb begin
    r4 = 48'(pa >>> 30);
    r6 = 48'(pc >>> 30);
  end

  // r2^2 and k2 r2
  rcp_mul u_mul_r4  (.clk(clk), .a(36'(r2_r)), .b(r2_r), .p(pa));
  rcp_mul u_mul_k2  (.clk(clk), .a(36'(cfg.radial_k2)), .b(r2_r), .p(pb));
  // r4 r2 and k4 r4
  rcp_mul u_mul_r6  (.clk(clk), .a(36'(r2_d_r[1])), .b(r4), .p(pc));
  rcp_mul u_mul_k4  (.clk(clk), .a(36'(cfg.radial_k4)), .b(r4), .p(pd));
  // k6 r6
  rcp_mul u_mul_k6  (.clk(clk), .a(36'(cfg.radial_k6)), .b(r6), .p(pe));
  // offset times distortion
  rcp_mul u_mul_dx  (.clk(clk), .a(36'(ex_d_r[9])), .b(dist_r), .p(pf));
  rcp_mul u_mul_dy  (.clk(clk), .a(36'(ey_d_r[9])), .b(dist_r), .p(pg));

  always_ff @(posedge clk) begin
    ex_d_r[0] <= sat32(64'(xn) - 64'(cfg.dist_center_x));
    ey_d_r[0] <= sat32(64'(yn) - 64'(cfg.dist_center_y));
    for (int i = 1; i < 10; i++) begin
      ex_d_r[i] <= ex_d_r[i-1];
      ey_d_r[i] <= ey_d_r[i-1];
    end
    xn_d_r[0] <= xn;
    yn_d_r[0] <= yn;
    for (int i = 1; i < 12; i++) begin
      xn_d_r[i] <= xn_d_r[i-1];
      yn_d_r[i] <= yn_d_r[i-1];
    end
    sx_r <= 64'(ex_d_r[0]) * 64'(ex_d_r[0]);
    sy_r <= 64'(ey_d_r[0]) * 64'(ey_d_r[0]);
    r2_r <= 48'(sx_r >>> 30) + 48'(sy_r >>> 30);
    r2_d_r[0] <= r2_r;
    r2_d_r[1] <= r2_d_r[0];
    kr2_d_r[0] <= 48'(pb >>> 28);
    for (int i = 1; i < 4; i++) begin
      kr2_d_r[i] <= kr2_d_r[i-1];
    end
    kr4_d_r[0] <= 48'(pd >>> 28);
    kr4_d_r[1] <= kr4_d_r[0];
    dist_r <= kr2_d_r[3] + kr4_d_r[1] + 48'(pe >>> 28);
    xd <= 48'(xn_d_r[11]) + 48'(pf >>> 30);
    yd <= 48'(yn_d_r[11]) + 48'(pg >>> 30);
  end
endmodule

@@ rtl/core/rcp_pixel.sv @@
// focal scaling, principal point, residual against observed pixel, saturation
// three register stages; uses rcp_pkg and rcp_mul
module rcp_pixel (
  input  logic                clk,
  input  rcp_pkg::cfg_t       cfg,
  input  logic signed [47:0]  xd,
  input  logic signed [47:0]  yd,
  input  logic signed [31:0]  obs_x,
  input  logic signed [31:0]  obs_y,
  input  logic                zero,
  output logic signed [31:0]  res_x,
  output logic signed [31:0]  res_y,
  output logic                res_zero
);
  import rcp_pkg::*;

  logic signed [83:0] px, py;
  logic signed [31:0] obs_x_r [0:1];
  logic signed [31:0] obs_y_r [0:1];
  logic               zero_r  [0:1];
  logic signed [63:0] sum_x, sum_y;

  rcp_mul u_mul_fx (.clk(clk), .a({5'b0, cfg.focal_length}), .b(xd), .p(px));
  rcp_mul u_mul_fy (.clk(clk), .a({5'b0, cfg.focal_length}), .b(yd), .p(py));

  always_comb begin
    sum_x = 64'(cfg.principal_x) + 64'(48'(px >>> 30)) - 64'(obs_x_r[1]);
    sum_y = 64'(cfg.principal_y) + 64'(48'(py >>> 30)) - 64'(obs_y_r[1]);
  end

  always_ff @(posedge clk) begin
    obs_x_r[0] <= obs_x;
    obs_y_r[0] <= obs_y;
    zero_r[0]  <= zero;
    obs_x_r[1] <= obs_x_r[0];
    obs_y_r[1] <= obs_y_r[0];
    zero_r[1]  <= zero_r[0];
    res_x      <= zero_r[1] ? '0 : sat32(sum_x);
    res_y      <= zero_r[1] ? '0 : sat32(sum_y);
    res_zero   <= zero_r[1];
  end
endmodule

@@ rtl/core/radial_camera_projection_residual.sv @@
// top level of the radial pinhole projection residual core
// uses rcp_pkg, rcp_rotate, rcp_div, rcp_distort, rcp_pixel
//
//  channel  | handshake              | word
//  ---------+------------------------+--------------------------------------------
//  input    | start, busy            | ground, centre, omega, observed pixel
//  result   | out_valid (one cycle)  | residual_x, residual_y, zero_depth
//  config   | cfg_we, cfg_index      | cfg_data, 8 registers, no read-back
//
// a word enters on every cycle; its result strobes once it has passed, in order, the
// rotation (3), the 32-stage divider (quotient bits, then sign), the distortion
// multiplier chain (13) and the pixel stage (3)
// busy stays low: the pipeline always advances and the receiver cannot stall it
// synchronous reset clears the valid chain and loads the register defaults
module radial_camera_projection_residual (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_ground_x,
  input  logic signed [31:0] in_ground_y,
  input  logic signed [31:0] in_ground_z,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_omega_x,
  input  logic signed [31:0] in_omega_y,
  input  logic signed [31:0] in_omega_z,
  input  logic signed [31:0] in_observed_x,
  input  logic signed [31:0] in_observed_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_residual_x,
  output logic signed [31:0] out_residual_y,
  output logic               out_zero_depth
);
  import rcp_pkg::*;

  cfg_t               cfg_r, cfg_nxt;
  logic [LAT-1:0]     vld_r, vld_nxt;

  // observed pixel rides alongside until the pixel stage
  logic signed [31:0] obx_d_r [0:OBS_DLY-1];
  logic signed [31:0] oby_d_r [0:OBS_DLY-1];
  logic               zero_d_r [0:ZERO_DLY-1];

  logic signed [35:0] xc, yc, zc;
  logic               zero;
  logic signed [31:0] xn, yn;
  logic signed [47:0] xd, yd;

  assign busy = 1'b0;

  // register writes, index decoded by name
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DIST_CENTER_X: cfg_nxt.dist_center_x = cfg_data;
        REG_DIST_CENTER_Y: cfg_nxt.dist_center_y = cfg_data;
        REG_RADIAL_K2:     cfg_nxt.radial_k2     = cfg_data;
        REG_RADIAL_K4:     cfg_nxt.radial_k4     = cfg_data;
        REG_RADIAL_K6:     cfg_nxt.radial_k6     = cfg_data;
        REG_PRINCIPAL_X:   cfg_nxt.principal_x   = cfg_data;
        REG_PRINCIPAL_Y:   cfg_nxt.principal_y   = cfg_data;
        REG_FOCAL_LENGTH:  cfg_nxt.focal_length  = cfg_data[30:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
    // valid bit follows each word down the pipe
    vld_nxt = {vld_r[LAT-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dist_center_x: '0,
                 dist_center_y: '0,
                 radial_k2:     '0,
                 radial_k4:     '0,
                 radial_k6:     '0,
                 principal_x:   PRINCIPAL_X_RST,
                 principal_y:   PRINCIPAL_Y_RST,
                 focal_length:  FOCAL_LENGTH_RST};
      vld_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  // side-band delay lines, payload only
  always_ff @(posedge clk) begin
    obx_d_r[0] <= in_observed_x;
    oby_d_r[0] <= in_observed_y;
    for (int i = 1; i < OBS_DLY; i++) begin
      obx_d_r[i] <= obx_d_r[i-1];
      oby_d_r[i] <= oby_d_r[i-1];
    end
    zero_d_r[0] <= zero;
    for (int i = 1; i < ZERO_DLY; i++) begin
      zero_d_r[i] <= zero_d_r[i-1];
    end
  end

  // camera frame point
  rcp_rotate u_rotate (
    .clk      (clk),
    .ground_x (in_ground_x),
    .ground_y (in_ground_y),
    .ground_z (in_ground_z),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .center_z (in_center_z),
    .omega_x  (in_omega_x),
    .omega_y  (in_omega_y),
    .omega_z  (in_omega_z),
    .xc       (xc),
    .yc       (yc),
    .zc       (zc),
    .zero     (zero)
  );

  // normalized coordinates, two dividers share the depth
  rcp_div u_div_x (.clk(clk), .num(xc), .den(zc), .q(xn));
  rcp_div u_div_y (.clk(clk), .num(yc), .den(zc), .q(yn));

  // lens distortion
  rcp_distort u_distort (
    .clk (clk),
    .cfg (cfg_r),
    .xn  (xn),
    .yn  (yn),
    .xd  (xd),
    .yd  (yd)
  );

  // pixel mapping and residual; zero depth forces both residuals to zero
  rcp_pixel u_pixel (
    .clk      (clk),
    .cfg      (cfg_r),
    .xd       (xd),
    .yd       (yd),
    .obs_x    (obx_d_r[OBS_DLY-1]),
    .obs_y    (oby_d_r[OBS_DLY-1]),
    .zero     (zero_d_r[ZERO_DLY-1]),
    .res_x    (out_residual_x),
    .res_y    (out_residual_y),
    .res_zero (out_zero_depth)
  );

  assign out_valid = vld_r[LAT-1];
endmodule

@@ rtl/core/rcp_checker.sv @@
// port-level checks for the projection residual core, bound to the top level
// uses rcp_pkg and assert_macros.svh
`include "assert_macros.svh"

module rcp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_ground_x,
  input logic signed [31:0] in_ground_y,
  input logic signed [31:0] in_ground_z,
  input logic signed [31:0] in_center_x,
  input logic signed [31:0] in_center_y,
  input logic signed [31:0] in_center_z,
  input logic               out_valid,
  input logic signed [31:0] out_residual_x,
  input logic signed [31:0] out_residual_y,
  input logic               out_zero_depth
);
  import rcp_pkg::*;

  // every result word traces back to an accepted word a fixed latency earlier
  `RCP_ASSERT(a_valid_origin, out_valid |-> $past(start && !busy, LAT), "result without word")

  // zero depth forces both residuals to zero
  `RCP_ASSERT(a_zero_forces, (out_valid && out_zero_depth) |-> (out_residual_x == 0 && out_residual_y == 0), "zero depth residual nonzero")

  // a point on the camera centre has zero depth
  `RCP_ASSERT(a_centre_point, (start && !busy && in_ground_x == in_center_x && in_ground_y == in_center_y && in_ground_z == in_center_z) |-> ##LAT (out_valid && out_zero_depth), "centre point missed zero depth")

  // reset drains the pipe at once
  `RCP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "strobe after reset")
endmodule

bind radial_camera_projection_residual rcp_checker u_rcp_checker (.*);

@@ dv/tb.sv @@
// self-checking testbench for the radial pinhole projection residual core
// depends on rcp_pkg and radial_camera_projection_residual; holds its own bit-exact predictor
`timescale 1ns / 1ps

module tb;
  import rcp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles with no accept and no result

  typedef struct {
    logic signed [31:0] gx, gy, gz, cx, cy, cz, wx, wy, wz, obx, oby;
  } obs_word_t;

  typedef struct {
    logic signed [31:0] res_x, res_y;
    logic zdep;
  } residual_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_ground_x = '0, in_ground_y = '0, in_ground_z = '0;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [31:0] in_omega_x = '0, in_omega_y = '0, in_omega_z = '0;
  logic signed [31:0] in_observed_x = '0, in_observed_y = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic signed [31:0] out_residual_x, out_residual_y;
  logic out_zero_depth;

  // shadow copy of the intrinsics; focal length zero-extended, the rest sign-extended
  logic signed [63:0] intr [8];
  residual_t pending_residuals [$];
  int err_count = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;

  radial_camera_projection_residual dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor(a*b / 2^s), magnitude clamped at 2^62
  function automatic logic signed [63:0] fixmul(logic signed [63:0] a, logic signed [63:0] b,
                                                int s);
    logic signed [127:0] aw, bw, p;
    aw = a;
    bw = b;
    p = (aw * bw) >>> s;
    if (p > (128'sd1 <<< 62)) p = 128'sd1 <<< 62;
    if (p < -(128'sd1 <<< 62)) p = -(128'sd1 <<< 62);
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // quotient in q2.30, truncated toward zero, saturated
  function automatic logic signed [63:0] ratio_q30(logic signed [63:0] n, logic signed [63:0] d);
    logic signed [127:0] nw, dw, un, ud, m;
    nw = n;
    dw = d;
    un = nw < 0 ? -nw : nw;
    ud = dw < 0 ? -dw : dw;
    if (un >= 2 * ud) m = 128'sd1 <<< 31;
    else m = (un <<< 30) / ud;
    if ((n < 0) != (d < 0)) m = -m;
    return clamp32(m[63:0]);
  endfunction

  function automatic residual_t project_residual(obs_word_t w);
    logic signed [63:0] dx, dy, dz, xc, yc, zc, xn, yn, ex, ey, r2, r4, r6, dist_sum, xd, yd,
                        xi, yi;
    residual_t r;
    dx = 64'(w.gx) - 64'(w.cx);
    dy = 64'(w.gy) - 64'(w.cy);
    dz = 64'(w.gz) - 64'(w.cz);
    xc = dx + fixmul(w.wy, dz, 30) - fixmul(w.wz, dy, 30);
    yc = dy + fixmul(w.wz, dx, 30) - fixmul(w.wx, dz, 30);
    zc = dz + fixmul(w.wx, dy, 30) - fixmul(w.wy, dx, 30);
    r.res_x = '0;
    r.res_y = '0;
    r.zdep = 1'b1;
    if (zc != 0) begin
      xn = ratio_q30(xc, zc);
      yn = ratio_q30(yc, zc);
      ex = clamp32(xn - intr[REG_DIST_CENTER_X]);
      ey = clamp32(yn - intr[REG_DIST_CENTER_Y]);
      r2 = fixmul(ex, ex, 30) + fixmul(ey, ey, 30);
      r4 = fixmul(r2, r2, 30);
      r6 = fixmul(r4, r2, 30);
      dist_sum = fixmul(intr[REG_RADIAL_K2], r2, 28) + fixmul(intr[REG_RADIAL_K4], r4, 28)
               + fixmul(intr[REG_RADIAL_K6], r6, 28);
      xd = xn + fixmul(ex, dist_sum, 30);
      yd = yn + fixmul(ey, dist_sum, 30);
      xi = intr[REG_PRINCIPAL_X] + fixmul(intr[REG_FOCAL_LENGTH], xd, 30);
      yi = intr[REG_PRINCIPAL_Y] + fixmul(intr[REG_FOCAL_LENGTH], yd, 30);
      r.res_x = 32'(clamp32(xi - 64'(w.obx)));
      r.res_y = 32'(clamp32(yi - 64'(w.oby)));
      r.zdep = 1'b0;
    end
    return r;
  endfunction

  // accept monitor: predict on every accepted word, then track register writes
  always @(posedge clk) begin
    obs_word_t w;
    if (!rst_n) begin
      foreach (intr[i]) intr[i] = 0;
      intr[REG_PRINCIPAL_X] = PRINCIPAL_X_RST;
      intr[REG_PRINCIPAL_Y] = PRINCIPAL_Y_RST;
      intr[REG_FOCAL_LENGTH] = 64'(FOCAL_LENGTH_RST);
    end else begin
      if (start && !busy) begin
        w.gx = in_ground_x;  w.gy = in_ground_y;  w.gz = in_ground_z;
        w.cx = in_center_x;  w.cy = in_center_y;  w.cz = in_center_z;
        w.wx = in_omega_x;   w.wy = in_omega_y;   w.wz = in_omega_z;
        w.obx = in_observed_x;  w.oby = in_observed_y;
        pending_residuals = {pending_residuals, project_residual(w)};
      end
      // a write lands after this edge's prediction
      if (cfg_we) begin
        if (cfg_index == REG_FOCAL_LENGTH) intr[cfg_index] = 64'(cfg_data[30:0]);
        else intr[cfg_index] = 64'($signed(cfg_data));
      end
    end
  end

  // result checker: every strobe pairs with the oldest prediction
  always @(posedge clk) begin
    residual_t e;
    if (rst_n && out_valid) begin
      if (pending_residuals.size() == 0) begin
        $error("result word with no prediction waiting");
        err_count++;
      end else begin
        e = pending_residuals.pop_front();
        if (out_residual_x !== e.res_x) begin
          $error("residual_x: expected %0d actual %0d", e.res_x, out_residual_x);
          err_count++;
        end
        if (out_residual_y !== e.res_y) begin
          $error("residual_y: expected %0d actual %0d", e.res_y, out_residual_y);
          err_count++;
        end
        if (out_zero_depth !== e.zdep) begin
          $error("zero_depth: expected %0b actual %0b", e.zdep, out_zero_depth);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // send one word; start stays high between back-to-back words
  // called right after a rising edge, returns right after the accepting edge
  task automatic send_word(obs_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_ground_x <= w.gx;  in_ground_y <= w.gy;  in_ground_z <= w.gz;
    in_center_x <= w.cx;  in_center_y <= w.cy;  in_center_z <= w.cz;
    in_omega_x <= w.wx;   in_omega_y <= w.wy;   in_omega_z <= w.wz;
    in_observed_x <= w.obx;  in_observed_y <= w.oby;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // lower start, then wait until every result is back
  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_residuals.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic obs_word_t noise_word();
    obs_word_t w;
    w.gx = $urandom;  w.gy = $urandom;  w.gz = $urandom;
    w.cx = $urandom;  w.cy = $urandom;  w.cz = $urandom;
    w.wx = $urandom;  w.wy = $urandom;  w.wz = $urandom;
    w.obx = $urandom;  w.oby = $urandom;
    return w;
  endfunction

  // plausible observation: point mostly in front of the camera, small rotation
  function automatic obs_word_t scene_word();
    obs_word_t w;
    w.cx = $signed($urandom_range(2000000)) - 1000000;
    w.cy = $signed($urandom_range(2000000)) - 1000000;
    w.cz = $signed($urandom_range(2000000)) - 1000000;
    w.gx = w.cx + $signed($urandom_range(8000000)) - 4000000;
    w.gy = w.cy + $signed($urandom_range(8000000)) - 4000000;
    w.gz = w.cz + $signed($urandom_range(20000000, 100));
    if ($urandom_range(9) == 0) w.gz = -w.gz + 2 * w.cz;  // behind the camera
    w.wx = $signed($urandom_range(2000000)) - 1000000;
    w.wy = $signed($urandom_range(2000000)) - 1000000;
    w.wz = $signed($urandom_range(2000000)) - 1000000;
    w.obx = $signed($urandom_range(500000000)) - 50000000;
    w.oby = $signed($urandom_range(400000000)) - 50000000;
    if ($urandom_range(19) == 0) begin
      // no rotation and equal depth: zero-depth case
      w.gz = w.cz;
      w.wx = 0;  w.wy = 0;  w.wz = 0;
    end
    return w;
  endfunction

  task automatic load_intrinsics(logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
  endtask

  task automatic test_directed();
    obs_word_t w;
    logic [31:0] ext [4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    // every field at its extremes together
    foreach (ext[i]) begin
      w.gx = ext[i];  w.gy = ext[i];  w.gz = ext[i];
      w.cx = ext[3 - i];  w.cy = ext[3 - i];  w.cz = ext[3 - i];
      w.wx = ext[i];  w.wy = ext[3 - i];  w.wz = ext[i];
      w.obx = ext[i];  w.oby = ext[3 - i];
      send_word(w);
    end
    // zero depth with no rotation
    w = scene_word();
    w.gz = w.cz;  w.wx = 0;  w.wy = 0;  w.wz = 0;
    send_word(w);
    // ground on the centre: all zero
    w.gx = w.cx;  w.gy = w.cy;
    send_word(w);
    // huge ratio, both signs
    w = scene_word();
    w.gz = w.cz + 1;  w.gx = w.cx + 32'sd100000;  w.gy = w.cy - 32'sd100000;
    w.wx = 0;  w.wy = 0;  w.wz = 0;
    send_word(w);
    w.gz = w.cz - 1;
    send_word(w);
    // residual overflow both ways through the observed pixel
    w = scene_word();
    w.obx = 32'h80000000;  w.oby = 32'h7fffffff;
    send_word(w);
    w.obx = 32'h7fffffff;  w.oby = 32'h80000000;
    send_word(w);
    // rotation only at its extremes
    w = scene_word();
    w.wx = 32'h7fffffff;  w.wy = 32'h80000000;  w.wz = 32'h7fffffff;
    send_word(w);
    drain_pipe();
  endtask

  // intrinsics at their extremes with strong distortion
  task automatic test_extreme_intrinsics();
    logic [31:0] v [8];
    v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h7fffffff, 32'h80000000, 32'hffffffff};
    load_intrinsics(v);
    for (int i = 0; i < 8; i++) send_word(i < 4 ? scene_word() : noise_word());
    drain_pipe();
    v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'h7fffffff, 32'h0};
    load_intrinsics(v);
    for (int i = 0; i < 6; i++) send_word(i < 3 ? scene_word() : noise_word());
    drain_pipe();
  endtask

  // one random phase: fresh intrinsics, then a stream of mostly plausible words
  task automatic test_random_stream(int gap_pct, int n_words);
    logic [31:0] v [8];
    send_gap_pct = gap_pct;
    if ($urandom_range(3) == 0) begin
      foreach (v[i]) v[i] = $urandom;
    end else begin
      v[REG_DIST_CENTER_X] = $signed($urandom_range(200000000)) - 100000000;
      v[REG_DIST_CENTER_Y] = $signed($urandom_range(200000000)) - 100000000;
      v[REG_RADIAL_K2] = $signed($urandom_range(60000000)) - 30000000;
      v[REG_RADIAL_K4] = $signed($urandom_range(20000000)) - 10000000;
      v[REG_RADIAL_K6] = $signed($urandom_range(6000000)) - 3000000;
      v[REG_PRINCIPAL_X] = $urandom_range(300000000);
      v[REG_PRINCIPAL_Y] = $urandom_range(200000000);
      // top bit random: ignored above the focal length width
      v[REG_FOCAL_LENGTH] = {1'($urandom), 31'($urandom_range(800000000))};
    end
    load_intrinsics(v);
    for (int i = 0; i < n_words; i++) begin
      // bursts with no gaps now and then
      if ($urandom_range(49) == 0) send_gap_pct = send_gap_pct == 0 ? gap_pct : 0;
      send_word($urandom_range(4) == 0 ? noise_word() : scene_word());
    end
    drain_pipe();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_extreme_intrinsics();
    test_random_stream(35, 250);
    test_random_stream(49, 250);
    test_random_stream(0, 250);
    repeat (LAT + 10) @(posedge clk);
    if (err_count == 0 && pending_residuals.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rcp_pkg.sv
rtl/core/rcp_mul.sv
rtl/core/rcp_rotate.sv
rtl/core/rcp_div.sv
rtl/core/rcp_distort.sv
rtl/core/rcp_pixel.sv
rtl/core/radial_camera_projection_residual.sv
rtl/core/rcp_checker.sv
dv/tb.sv
